>>> rtl/abbc_pkg.sv
// Package for the alpha bounding-box crop block: widths, limits, shared types.
// No dependencies; every other file imports it.
`default_nettype none

package abbc_pkg;

  localparam int unsigned CoordW  = 12;
  localparam int unsigned DimW    = 13;
  localparam int unsigned AlphaW  = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned MaxDim  = 4096;
  localparam int unsigned OutW    = 2 * CoordW + 2 * DimW;
  localparam int unsigned OutBytesW = ((OutW + 7) / 8) * 8;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [DimW-1:0]   dim_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWidth  = 2'd0,
    CfgHeight = 2'd1
  } cfg_idx_e;

  // Inclusive box of opaque pixels; all zero when no opaque pixel was seen.
  typedef struct packed {
    coord_t x0;
    coord_t x1;
    coord_t y0;
    coord_t y1;
  } box_t;

  // Last column and last row of the image.
  typedef struct packed {
    coord_t wd_m1;
    coord_t ht_m1;
  } lim_t;

  typedef struct packed {
    dim_t   h;
    dim_t   w;
    coord_t y;
    coord_t x;
  } crop_t;

  function automatic coord_t last_index(input dim_t v);
    coord_t r;
    r = '0;
    if (v == '0) begin
      r = '0;
    end else if (v > dim_t'(MaxDim)) begin
      r = coord_t'(MaxDim - 1);
    end else begin
      r = coord_t'(v - dim_t'(1));
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/abbc_crop_adjust.sv
// Margin and even-crop adjustment of the final box, with the result register.
// Depends on abbc_pkg.
`default_nettype none

module abbc_crop_adjust (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          box_valid_i,
  output logic               box_ready_o,
  input  wire abbc_pkg::box_t box_i,
  input  wire abbc_pkg::lim_t lim_i,
  output logic               crop_valid_o,
  input  wire logic          crop_ready_i,
  output abbc_pkg::crop_t    crop_o
);
  import abbc_pkg::*;

  typedef struct packed {
    coord_t lo;
    dim_t   len;
  } span_t;

  function automatic span_t axis_crop(input coord_t lo, input coord_t hi, input coord_t lm1);
    coord_t lo1, hi1, lo2, hi2;
    logic   odd;
    span_t  s;
    lo1 = (lo != '0) ? coord_t'(lo - coord_t'(1)) : '0;
    hi1 = (hi < lm1) ? coord_t'(hi + coord_t'(1)) : hi;
    // (limit - len) odd: limit parity is ~lm1[0], len parity is ~(hi1[0]^lo1[0])
    odd = lm1[0] ^ hi1[0] ^ lo1[0];
    lo2 = lo1;
    hi2 = hi1;
    if (odd) begin
      if (lo1 != '0) begin
        lo2 = coord_t'(lo1 - coord_t'(1));
      end else begin
        hi2 = coord_t'(hi1 + coord_t'(1));
      end
    end
    s.lo  = lo2;
    s.len = dim_t'({1'b0, hi2} - {1'b0, lo2} + dim_t'(1));
    return s;
  endfunction

  logic  s2_valid_q, s2_valid_d;
  box_t  s2_box_q;
  logic  out_valid_q, out_valid_d;
  crop_t out_q, out_d;
  logic  s2_move;
  span_t sx, sy;

  assign s2_move     = s2_valid_q && (!out_valid_q || crop_ready_i);
  assign box_ready_o = !s2_valid_q || s2_move;

  always_comb begin
    sx = axis_crop(s2_box_q.x0, s2_box_q.x1, lim_i.wd_m1);
    sy = axis_crop(s2_box_q.y0, s2_box_q.y1, lim_i.ht_m1);
    out_d.x = sx.lo;
    out_d.w = sx.len;
    out_d.y = sy.lo;
    out_d.h = sy.len;
  end

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (box_valid_i && box_ready_o) begin
      s2_valid_d = 1'b1;
    end else if (s2_move) begin
      s2_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s2_move) begin
      out_valid_d = 1'b1;
    end else if (crop_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (box_valid_i && box_ready_o) begin
      s2_box_q <= box_i;
    end
    if (s2_move) begin
      out_q <= out_d;
    end
  end

  assign crop_valid_o = out_valid_q;
  assign crop_o       = out_q;

endmodule

`default_nettype wire

>>> rtl/alpha_bounding_box_crop.sv
// The box of an image moves from the pixel stage to the box register, then to the result register.
// Throughput: one pixel beat per cycle; the input stalls only when the pixel
// register holds the last pixel of an image while the box and result registers are full and m_axis_tready is low.
// Reset: all valid flags, position and box cleared; width and height read as 1.
// Top level: pixel register, position counters and running min/max box.
// Depends on abbc_pkg and abbc_crop_adjust.
`default_nettype none

module alpha_bounding_box_crop (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,   // [7:0] alpha
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [11:0] crop_x, [23:12] crop_y, [36:24] crop_w, [49:37] crop_h, [55:50] zero
  output logic [abbc_pkg::OutBytesW-1:0]       m_axis_tdata,
  input  wire logic                            cfg_we_i,
  input  wire logic [abbc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [abbc_pkg::DimW-1:0]       cfg_data_i
);
  import abbc_pkg::*;

  logic              s1_valid_q, s1_valid_d;
  logic [AlphaW-1:0] s1_alpha_q;
  lim_t              lim_q, lim_d;
  coord_t            col_q, col_d, row_q, row_d;
  box_t              box_q, box_d;
  logic              seen_q, seen_d;
  logic              restart;
  logic              s1_last, s1_fire, opaque;
  logic              adj_ready;
  crop_t             crop;

  assign s1_last       = (col_q >= lim_q.wd_m1) && (row_q >= lim_q.ht_m1);
  assign s1_fire       = s1_valid_q && (!s1_last || adj_ready);
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign opaque        = (s1_alpha_q != '0);

  always_comb begin
    lim_d   = lim_q;
    restart = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgWidth: begin
          lim_d.wd_m1 = last_index(cfg_data_i);
          restart     = 1'b1;
        end
        CfgHeight: begin
          lim_d.ht_m1 = last_index(cfg_data_i);
          restart     = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  // Box including the current pixel, and the next position; the box feeds both the state and the adjust stage.
  always_comb begin
    box_d  = box_q;
    seen_d = seen_q;
    if (opaque) begin
      seen_d = 1'b1;
      if (!seen_q) begin
        box_d.x0 = col_q;
        box_d.x1 = col_q;
        box_d.y0 = row_q;
        box_d.y1 = row_q;
      end else begin
        if (col_q < box_q.x0) box_d.x0 = col_q;
        if (col_q > box_q.x1) box_d.x1 = col_q;
        if (row_q < box_q.y0) box_d.y0 = row_q;
        if (row_q > box_q.y1) box_d.y1 = row_q;
      end
    end
    if (col_q >= lim_q.wd_m1) begin
      col_d = '0;
      row_d = coord_t'(row_q + coord_t'(1));
    end else begin
      col_d = coord_t'(col_q + coord_t'(1));
      row_d = row_q;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      lim_q      <= '0;
      col_q      <= '0;
      row_q      <= '0;
      box_q      <= '0;
      seen_q     <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      lim_q      <= lim_d;
      if (restart || (s1_fire && s1_last)) begin
        col_q  <= '0;
        row_q  <= '0;
        box_q  <= '0;
        seen_q <= 1'b0;
      end else if (s1_fire) begin
        col_q  <= col_d;
        row_q  <= row_d;
        box_q  <= box_d;
        seen_q <= seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_alpha_q <= s_axis_tdata;
    end
  end

  abbc_crop_adjust u_adjust (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .box_valid_i  (s1_valid_q && s1_last),
    .box_ready_o  (adj_ready),
    .box_i        (box_d),
    .lim_i        (lim_q),
    .crop_valid_o (m_axis_tvalid),
    .crop_ready_i (m_axis_tready),
    .crop_o       (crop)
  );

  assign m_axis_tdata = {{(OutBytesW - OutW){1'b0}}, crop.h, crop.w, crop.y, crop.x};

endmodule

`default_nettype wire

>>> rtl/abbc_checker.sv
// Port-level checker for alpha_bounding_box_crop, attached by bind.
// Depends on abbc_pkg and the top level's port names.
`default_nettype none

module abbc_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [abbc_pkg::OutBytesW-1:0] m_axis_tdata
);
  import abbc_pkg::*;

  logic [DimW:0] x_end;
  logic [DimW:0] y_end;

  assign x_end = {2'b00, m_axis_tdata[11:0]} + {1'b0, m_axis_tdata[36:24]};
  assign y_end = {2'b00, m_axis_tdata[23:12]} + {1'b0, m_axis_tdata[49:37]};

  a_reset_clears: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result beat valid right after reset");

  a_hold_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result beat changed or dropped");

  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[36:24] != '0) && (m_axis_tdata[49:37] != '0))
    else $error("crop rectangle is empty");

  a_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (x_end <= (DimW+1)'(MaxDim)) && (y_end <= (DimW+1)'(MaxDim)))
    else $error("crop rectangle leaves the largest image");

endmodule

bind alpha_bounding_box_crop abbc_checker u_abbc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> test/tb_alpha_bounding_box_crop.sv
// Testbench for alpha_bounding_box_crop: streams alpha images and checks each crop beat
// against a cycle-free predictor of the bounding box, margin and even-crop rules.
// Depends on abbc_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_alpha_bounding_box_crop;
  import abbc_pkg::*;

  typedef enum int {ModeFree, ModeSendIdle, ModeRecvStall, ModeBoth} idle_mode_e;
  typedef enum int {FillClear, FillSingle, FillSparse, FillDense} fill_e;

  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd2;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;    // [7:0] alpha
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [11:0] crop_x, [23:12] crop_y, [36:24] crop_w, [49:37] crop_h, rest zero
  logic [OutBytesW-1:0] m_axis_tdata;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [DimW-1:0]      cfg_data_i = '0;

  alpha_bounding_box_crop dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  logic [7:0]  pix_q[$];
  crop_t       crop_q[$];
  idle_mode_e  idle_mode = ModeFree;
  logic        pix_taken = 1'b0;
  logic        rx_hold = 1'b0;
  logic        hold_go = 1'b0;
  int unsigned err_cnt = 0;

  dim_t        width_reg = 13'd1;
  dim_t        height_reg = 13'd1;
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  int unsigned min_col = 0;
  int unsigned max_col = 0;
  int unsigned min_row = 0;
  int unsigned max_row = 0;
  bit          seen_opaque = 1'b0;

  function automatic int unsigned clamp_dim(dim_t v);
    if (v == '0) return 1;
    if (v > dim_t'(MaxDim)) return MaxDim;
    return int'(v);
  endfunction

  function automatic void restart_box();
    col_pos = 0;
    row_pos = 0;
    min_col = 0;
    max_col = 0;
    min_row = 0;
    max_row = 0;
    seen_opaque = 1'b0;
  endfunction

  task automatic crop_predict(input logic [7:0] alpha);
    int unsigned wd, ht, x, y, w, h;
    bit          last;
    crop_t       want;
    wd = clamp_dim(width_reg);
    ht = clamp_dim(height_reg);
    last = (col_pos >= wd - 1) && (row_pos >= ht - 1);
    if (alpha != 8'd0) begin
      if (!seen_opaque) begin
        min_col = col_pos;
        max_col = col_pos;
        min_row = row_pos;
        max_row = row_pos;
        seen_opaque = 1'b1;
      end else begin
        if (col_pos < min_col) min_col = col_pos;
        if (col_pos > max_col) max_col = col_pos;
        if (row_pos < min_row) min_row = row_pos;
        if (row_pos > max_row) max_row = row_pos;
      end
    end
    if (col_pos >= wd - 1) begin
      col_pos = 0;
      row_pos = row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    if (last) begin
      if (seen_opaque) begin
        x = min_col;
        y = min_row;
        w = max_col - min_col + 1;
        h = max_row - min_row + 1;
      end else begin
        x = 0;
        y = 0;
        w = 1;
        h = 1;
      end
      if (x > 0) begin
        x--;
        w++;
      end
      if (y > 0) begin
        y--;
        h++;
      end
      if (x + w < wd) w++;
      if (y + h < ht) h++;
      if (((wd - w) & 1) != 0) begin
        if (x > 0) x--;
        w++;
      end
      if (((ht - h) & 1) != 0) begin
        if (y > 0) y--;
        h++;
      end
      want.x = coord_t'(x);
      want.y = coord_t'(y);
      want.w = dim_t'(w);
      want.h = dim_t'(h);
      crop_q.push_back(want);
      restart_box();
    end
  endtask

  function automatic bit send_idle();
    case (idle_mode)
      ModeSendIdle: return $urandom_range(99) < 55;
      ModeBoth:     return $urandom_range(99) < 15;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic bit recv_stall();
    case (idle_mode)
      ModeRecvStall: return $urandom_range(99) < 55;
      ModeBoth:      return $urandom_range(99) < 15;
      default:       return 1'b0;
    endcase
  endfunction

  always @(negedge clk_i) begin
    logic       nxt_valid;
    logic [7:0] nxt_data;
    nxt_valid = s_axis_tvalid && !pix_taken;
    nxt_data = s_axis_tdata;
    if (!nxt_valid && rst_ni && pix_q.size() != 0 && !send_idle()) begin
      nxt_valid = 1'b1;
      nxt_data = pix_q.pop_front();
    end
    s_axis_tvalid <= nxt_valid;
    s_axis_tdata <= nxt_data;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && !rx_hold && !recv_stall();
  end

  always @(posedge clk_i) begin
    crop_t want, got;
    pix_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) crop_predict(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = crop_t'(m_axis_tdata[OutW-1:0]);
      if (crop_q.size() == 0) begin
        $error("crop beat with none pending: x=%0d y=%0d w=%0d h=%0d",
               got.x, got.y, got.w, got.h);
        err_cnt++;
      end else begin
        want = crop_q.pop_front();
        if (got.x != want.x) begin
          $error("crop_x: expected %0d, got %0d", want.x, got.x);
          err_cnt++;
        end
        if (got.y != want.y) begin
          $error("crop_y: expected %0d, got %0d", want.y, got.y);
          err_cnt++;
        end
        if (got.w != want.w) begin
          $error("crop_w: expected %0d, got %0d", want.w, got.w);
          err_cnt++;
        end
        if (got.h != want.h) begin
          $error("crop_h: expected %0d, got %0d", want.h, got.h);
          err_cnt++;
        end
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering beats.
  initial begin
    wait (hold_go);
    @(negedge clk_i);
    rx_hold <= 1'b1;
    repeat (200) @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic drain();
    while (pix_q.size() != 0 || s_axis_tvalid || crop_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input dim_t val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx == CfgWidth) begin
      width_reg = val;
      restart_box();
    end else if (idx == CfgHeight) begin
      height_reg = val;
      restart_box();
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] opaque_alpha();
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic queue_pixels(input int unsigned total, input fill_e fill);
    int unsigned spot;
    logic [7:0]  a;
    spot = $urandom_range(total - 1);
    for (int unsigned i = 0; i < total; i++) begin
      case (fill)
        FillSingle: a = (i == spot) ? opaque_alpha() : 8'd0;
        FillSparse: a = ($urandom_range(7) == 0) ? opaque_alpha() : 8'd0;
        FillDense:  a = ($urandom_range(1) == 0) ? opaque_alpha() : 8'd0;
        default:    a = 8'd0;
      endcase
      pix_q.push_back(a);
    end
  endtask

  function automatic dim_t rand_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 80) return dim_t'($urandom_range(1, 8));
    return dim_t'($urandom_range(9, 24));
  endfunction

  initial begin
    int unsigned full, npix, part;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // 1x1 image after reset, transparent then opaque
    pix_q.push_back(8'h00);
    pix_q.push_back(8'hFF);
    cfg_write(CfgSpare, 13'd5);
    pix_q.push_back(8'h80);
    cfg_write(CfgWidth, 13'd0);
    cfg_write(CfgHeight, 13'd0);
    pix_q.push_back(8'h01);
    // 2x2 with one opaque pixel top right
    cfg_write(CfgWidth, 13'd2);
    cfg_write(CfgHeight, 13'd2);
    pix_q.push_back(8'h00);
    pix_q.push_back(8'h7F);
    pix_q.push_back(8'h00);
    pix_q.push_back(8'h00);
    // 5x2 split by an ignored write, then a partial image cut by a restart
    cfg_write(CfgWidth, 13'd5);
    cfg_write(CfgHeight, 13'd2);
    pix_q.push_back(8'h00);
    pix_q.push_back(8'h00);
    pix_q.push_back(8'h00);
    pix_q.push_back(8'h40);
    cfg_write(CfgSpare, 13'd3);
    repeat (6) pix_q.push_back(8'h00);
    pix_q.push_back(8'hFF);
    pix_q.push_back(8'h02);
    cfg_write(CfgWidth, 13'd4);
    cfg_write(CfgHeight, 13'd1);
    pix_q.push_back(8'h00);
    pix_q.push_back(8'h00);
    pix_q.push_back(8'h00);
    pix_q.push_back(8'hFF);

    // oversized and largest register values, partial images cut by a restart
    cfg_write(CfgWidth, 13'd8191);
    cfg_write(CfgHeight, 13'd4097);
    queue_pixels(40, FillSparse);
    cfg_write(CfgWidth, 13'd4096);
    cfg_write(CfgHeight, 13'd1);
    queue_pixels(40, FillSparse);

    for (int m = ModeFree; m <= ModeBoth; m++) begin
      drain();
      idle_mode = idle_mode_e'(m);
      npix = 0;
      while (npix < 130) begin
        cfg_write(CfgWidth, rand_dim());
        cfg_write(CfgHeight, rand_dim());
        full = clamp_dim(width_reg) * clamp_dim(height_reg);
        repeat ($urandom_range(1, 3)) begin
          queue_pixels(full, fill_e'($urandom_range(3)));
          npix += full;
        end
        if (full > 1 && $urandom_range(9) == 0) begin
          part = $urandom_range(1, full - 1);
          queue_pixels(part, fill_e'($urandom_range(3)));
          npix += part;
        end
      end
    end

    // fill the block while the receiver holds off
    drain();
    idle_mode = ModeFree;
    cfg_write(CfgWidth, 13'd1);
    cfg_write(CfgHeight, 13'd1);
    hold_go <= 1'b1;
    wait (rx_hold);
    queue_pixels(60, FillDense);

    drain();
    repeat (20) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
